### src/dtn_pkg.sv
// Package for the display text normalizer: payload structs, register map,
// and the byte decode functions. No dependencies.
package dtn_pkg;

  localparam int unsigned AddrW = 3;
  localparam logic [AddrW-1:0] RegMaxLength = 3'd0;
  localparam logic [7:0] MaxLengthReset = 8'd64;

  localparam logic [7:0] LeadByte = 8'hC3;
  localparam logic [6:0] SpaceChar = 7'h20;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic       char_valid;
    logic [6:0] out_char;
    logic       run_last;
    logic       text_end;
  } out_item_t;

  // glyph for continuation bytes 0x80..0xBF, by low five bits; 0 is a separator
  localparam logic [6:0] AccentMap [32] = '{
    7'h41, 7'h41, 7'h41, 7'h00, 7'h41, 7'h00, 7'h00, 7'h00,
    7'h45, 7'h45, 7'h45, 7'h45, 7'h49, 7'h49, 7'h49, 7'h49,
    7'h00, 7'h4E, 7'h4F, 7'h4F, 7'h4F, 7'h00, 7'h4F, 7'h00,
    7'h00, 7'h55, 7'h55, 7'h55, 7'h55, 7'h00, 7'h00, 7'h00
  };

  function automatic logic [6:0] decode_continuation(input logic [7:0] b);
    logic [6:0] g;
    g = 7'h00;
    if (b[7:6] == 2'b10) begin
      g = AccentMap[b[4:0]];
    end
    return g;
  endfunction

  function automatic logic [6:0] decode_ascii(input logic [7:0] b);
    logic [6:0] c;
    logic [6:0] g;
    c = b[6:0];
    g = 7'h00;
    if (c >= 7'h61 && c <= 7'h7A) begin
      c = c - 7'h20;
    end
    if (b[7] == 1'b0) begin
      if ((c >= 7'h41 && c <= 7'h5A) || (c >= 7'h30 && c <= 7'h39) ||
          c == 7'h25 || c == 7'h2D || c == 7'h2B || c == 7'h40 || c == 7'h5E) begin
        g = c;
      end
    end
    return g;
  endfunction

endpackage

### src/display_text_normalizer_top.sv
// Display text normalizer top level: byte decode, separator collapse,
// length limit and a small result queue. Depends on dtn_pkg.
//
//   channel | direction | handshake                 | payload
//   in      | input     | in_valid_i / in_stall_o   | in_data_i  (in_item_t)
//   out     | output    | out_valid_o / out_stall_i | out_data_o (out_item_t)
//   cfg     | input     | APB psel/penable/pready   | max_length at address 0
//
// One byte is decoded in the cycle it is accepted; its zero, one or two results
// are written into a four-entry registered result queue.
// A byte is accepted in every cycle while the queue has two free entries;
// a glyph after a separator adds two entries, so output drain sets the rate.
// Reset clears the queue, the text state and sets max_length to 64.
module display_text_normalizer_top
  import dtn_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW = $clog2(Depth);

  logic [7:0] max_length_q;
  logic       space_pending_q, space_pending_d;
  logic       lead_q, lead_d;
  logic [7:0] emitted_q, emitted_d;

  out_item_t       queue_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   cnt_q, cnt_d;

  logic       in_acc, out_acc;
  out_item_t  r0, r1;
  logic [1:0] n_res;
  logic [1:0] inc;
  logic [8:0] sum;

  assign pready = 1'b1;
  assign prdata = (paddr == RegMaxLength) ? {24'd0, max_length_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= MaxLengthReset;
    end else if (psel && penable && pwrite && pready && paddr == RegMaxLength) begin
      max_length_q <= pwdata[7:0];
    end
  end

  assign in_stall_o  = cnt_q > (PtrW+1)'(Depth - 2);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = cnt_q != '0;
  assign out_acc     = out_valid_o && !out_stall_i;
  assign out_data_o  = queue_q[rd_ptr_q];

  always_comb begin
    logic       held;
    logic [6:0] glyph;
    held            = 1'b0;
    glyph           = 7'h00;
    space_pending_d = space_pending_q;
    lead_d          = lead_q;
    r0              = '0;
    r1              = '0;
    n_res           = 2'd0;
    inc             = 2'd0;
    if (emitted_q < max_length_q) begin
      if (lead_q) begin
        lead_d = 1'b0;
        glyph  = decode_continuation(in_data_i.in_byte);
      end else if (in_data_i.in_byte == LeadByte && !in_data_i.is_last) begin
        lead_d = 1'b1;
        held   = 1'b1;
      end else begin
        glyph = decode_ascii(in_data_i.in_byte);
      end
      if (!held) begin
        if (glyph == 7'h00) begin
          space_pending_d = emitted_q != 8'd0;
        end else begin
          space_pending_d = 1'b0;
          if (space_pending_q) begin
            r0    = '{char_valid: 1'b1, out_char: SpaceChar, run_last: 1'b0, text_end: 1'b0};
            r1    = '{char_valid: 1'b1, out_char: glyph, run_last: 1'b1, text_end: 1'b0};
            n_res = 2'd2;
            inc   = 2'd2;
          end else begin
            r0    = '{char_valid: 1'b1, out_char: glyph, run_last: 1'b1, text_end: 1'b0};
            n_res = 2'd1;
            inc   = 2'd1;
          end
        end
      end
    end else begin
      lead_d = 1'b0;
    end

    sum       = {1'b0, emitted_q} + {7'd0, inc};
    emitted_d = sum[8] ? 8'hFF : sum[7:0];

    if (in_data_i.is_last) begin
      if (n_res == 2'd0) begin
        r0    = '{char_valid: 1'b0, out_char: 7'h00, run_last: 1'b1, text_end: 1'b1};
        n_res = 2'd1;
      end else if (n_res == 2'd1) begin
        r0.text_end = 1'b1;
      end else begin
        r1.text_end = 1'b1;
      end
      space_pending_d = 1'b0;
      lead_d          = 1'b0;
      emitted_d       = 8'd0;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc) begin
      cnt_d = cnt_d + {{(PtrW-1){1'b0}}, n_res};
    end
    if (out_acc) begin
      cnt_d = cnt_d - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      space_pending_q <= 1'b0;
      lead_q          <= 1'b0;
      emitted_q       <= 8'd0;
      wr_ptr_q        <= '0;
      rd_ptr_q        <= '0;
      cnt_q           <= '0;
    end else begin
      if (in_acc) begin
        space_pending_q <= space_pending_d;
        lead_q          <= lead_d;
        emitted_q       <= emitted_d;
        wr_ptr_q        <= wr_ptr_q + n_res[PtrW-1:0];
      end
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && n_res != 2'd0) begin
      queue_q[wr_ptr_q] <= r0;
      if (n_res == 2'd2) begin
        queue_q[wr_ptr_q + 1'b1] <= r1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(Depth))
    else $error("result queue overflow");

  a_last_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.is_last |=> cnt_q != '0)
    else $error("final byte left no result queued");

  a_last_clears_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.is_last |=> emitted_q == 8'd0 && !lead_q && !space_pending_q)
    else $error("text state not cleared after final byte");
`endif

endmodule
